// ----- rtl/can_mfr_pkg.sv -----
package can_mfr_pkg;

    localparam int BUF_BYTES_DEF = 4096;

    localparam int OP_W   = 2;
    localparam int ID_W   = 29;
    localparam int DLC_W  = 4;
    localparam int PL_W   = 64;
    localparam int RA_W   = 12;
    localparam int RD_W   = 8;
    localparam int BC_W   = 12;
    localparam int CNT_W  = 13;
    localparam int TAG_W  = 16;
    localparam int WA_W   = 12;
    localparam int IDX_W  = 3;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 40;

    localparam logic [CNT_W-1:0] MAX_RESET = 13'd4096;

    localparam logic [OP_W-1:0] OP_RX  = 2'd0;
    localparam logic [OP_W-1:0] OP_RD  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLR = 2'd2;

    typedef struct packed {
        logic load;
        logic hdr;
        logic byte_step;
        logic clr;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic tag_nz;
        logic dlc_zero;
        logic byte_last;
    } t_dp_stat;

endpackage

// ----- rtl/can_mfr_ctrl.sv -----
module can_mfr_ctrl
    import can_mfr_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_op,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  t_dp_stat        i_stat,
    output t_dp_cmd         o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BYTES = 2'd1;
    localparam logic [1:0] ST_FIN   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;

    assign accept      = i_in_valid && (r_state == ST_IDLE);
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_FIN;
                    if ((i_op == OP_RX) && !i_stat.tag_nz) begin
                        o_cmd.hdr = 1'b1;
                        if (!i_stat.dlc_zero) begin
                            n_state = ST_BYTES;
                        end
                    end else if (i_op == OP_CLR) begin
                        o_cmd.clr = 1'b1;
                    end
                end
            end
            ST_BYTES: begin
                o_cmd.byte_step = 1'b1;
                if (i_stat.byte_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/can_mfr_dp.sv -----
module can_mfr_dp
    import can_mfr_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  logic [OP_W-1:0]   i_op,
    input  logic [ID_W-1:0]   i_ext_id,
    input  logic [DLC_W-1:0]  i_dlc,
    input  logic [PL_W-1:0]   i_payload,
    input  logic [RA_W-1:0]   i_read_addr,
    output logic [RD_W-1:0]   o_read_data,
    output logic [BC_W-1:0]   o_byte_count,
    output logic [TAG_W-1:0]  o_done_tag,
    output logic              o_complete,
    output logic              o_frame_dropped
);

    localparam int AW = $clog2(BUF_BYTES);
    localparam logic [AW:0] BUF_LIM = (AW+1)'(BUF_BYTES);

    logic [RD_W-1:0]  mem [BUF_BYTES];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [TAG_W-1:0] r_tag;
    logic [TAG_W-1:0] n_tag;
    logic [CNT_W-1:0] r_max;

    logic [WA_W-1:0]  r_base;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_last_idx;
    logic [PL_W-1:0]  r_pay;
    logic             r_drop;
    logic             r_rd_sel;
    logic [RD_W-1:0]  r_mem_q;

    logic [RD_W-1:0]  r_o_rdata;
    logic [BC_W-1:0]  r_o_count;
    logic [TAG_W-1:0] r_o_tag;
    logic             r_o_drop;

    logic [3:0]       frame_num;
    logic [3:0]       frame_cnt;
    logic [9:0]       frames_seen;
    logic [8:0]       base_sum;
    logic [DLC_W-1:0] n_bytes;
    logic [CNT_W-1:0] cnt_inc;
    logic [WA_W-1:0]  wr_addr;
    logic [AW-1:0]    mem_addr;
    logic             rd_ok;

    assign frame_num   = i_ext_id[3:0];
    assign frame_cnt   = i_ext_id[7:4];
    assign frames_seen = r_count[CNT_W-1:3];
    assign base_sum    = {1'b0, i_ext_id[15:8]} + {5'd0, frame_num};
    assign n_bytes     = (i_dlc > 4'd8) ? 4'd8 : i_dlc;
    assign cnt_inc     = r_count + 13'd1;
    assign wr_addr     = r_base + {{(WA_W-IDX_W){1'b0}}, r_idx};
    assign mem_addr    = i_cmd.byte_step ? AW'(wr_addr) : AW'(i_read_addr);
    assign rd_ok       = (AW+1)'(i_read_addr) < BUF_LIM;

    assign o_stat.tag_nz    = (r_tag != '0);
    assign o_stat.dlc_zero  = (i_dlc == '0);
    assign o_stat.byte_last = (r_idx == r_last_idx);

    always_comb begin
        n_count = r_count;
        n_tag   = r_tag;
        if (i_cmd.clr) begin
            n_count = '0;
            n_tag   = '0;
        end
        if (i_cmd.hdr) begin
            if (frame_num == frame_cnt) begin
                if ((frames_seen == {6'd0, frame_cnt}) || (frame_cnt == 4'd0)) begin
                    n_tag = r_tag | i_ext_id[23:8];
                end
            end else if (frame_num == 4'd0) begin
                n_count = '0;
                n_tag   = '0;
            end
        end
        if (i_cmd.byte_step) begin
            if (cnt_inc >= r_max) begin
                n_count = '0;
                n_tag   = '0;
            end else begin
                n_count = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_tag   <= '0;
            r_max   <= MAX_RESET;
        end else begin
            r_count <= n_count;
            r_tag   <= n_tag;
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
        end
    end

    // single-port byte store
    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_step) begin
            mem[mem_addr] <= r_pay[RD_W-1:0];
        end
        if (i_cmd.load) begin
            r_mem_q <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base     <= {base_sum, 3'b000};
            r_idx      <= '0;
            r_last_idx <= IDX_W'(n_bytes - 4'd1);
            r_pay      <= i_payload;
            r_drop     <= (i_op == OP_RX) && (r_tag != '0);
            r_rd_sel   <= (i_op == OP_RD) && rd_ok;
        end else if (i_cmd.byte_step) begin
            r_idx <= r_idx + 3'd1;
            r_pay <= r_pay >> RD_W;
        end
        if (i_cmd.out_load) begin
            r_o_rdata <= r_rd_sel ? r_mem_q : '0;
            r_o_count <= r_count[BC_W-1:0];
            r_o_tag   <= r_tag;
            r_o_drop  <= r_drop;
        end
    end

    assign o_read_data     = r_o_rdata;
    assign o_byte_count    = r_o_count;
    assign o_done_tag      = r_o_tag;
    assign o_complete      = (r_o_tag != '0);
    assign o_frame_dropped = r_o_drop;

endmodule

// ----- rtl/can_multiframe_reassembler_core.sv -----
// flow: a received frame stores its payload bytes (dlc above 8 taken as 8) in ST_BYTES,
// then ST_FIN; reads, status clears, dropped and dlc-zero frames go straight to ST_FIN
// a new item is taken only once the last has left ST_FIN; bytes are stored one per cycle
// a result held by the receiver stalls the next item in ST_FIN, and the input, until taken
// reset: synchronous active-low; clears count, done tag, max_bytes to 4096 and handshakes
// the byte store is not cleared and holds undefined data until written
module can_multiframe_reassembler_core
    import can_mfr_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // ext_id, dlc, payload, read_addr, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // read_data, byte_count, done_tag, complete, frame_dropped, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CNT_W-1:0]      i_cfg_data
);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [RD_W-1:0]  read_data;
    logic [BC_W-1:0]  byte_count;
    logic [TAG_W-1:0] done_tag;
    logic             complete;
    logic             frame_dropped;

    assign o_cfg_ready = 1'b1;

    can_mfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_op        (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    can_mfr_dp #(
        .BUF_BYTES (BUF_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_op            (s_axis_tuser),
        .i_ext_id        (s_axis_tdata[28:0]),
        .i_dlc           (s_axis_tdata[32:29]),
        .i_payload       (s_axis_tdata[96:33]),
        .i_read_addr     (s_axis_tdata[108:97]),
        .o_read_data     (read_data),
        .o_byte_count    (byte_count),
        .o_done_tag      (done_tag),
        .o_complete      (complete),
        .o_frame_dropped (frame_dropped)
    );

    assign m_axis_tdata = {2'b00, frame_dropped, complete, done_tag, byte_count, read_data};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted again while item in progress");

    a_drop_needs_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && frame_dropped) |-> complete)
        else $error("frame dropped without a completed message");

    a_complete_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (complete == (done_tag != '0)))
        else $error("complete flag disagrees with done tag");

    a_no_store_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.byte_step |-> !s_axis_tready)
        else $error("store write while input side ready");

endmodule
